### src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`else

`define ASSERT_CLK(label, prop, msg)

`define ASSERT_NEXT(label, pre, post, msg)

`endif

`endif

### src/bfrim_pkg.sv
package bfrim_pkg;

    localparam int SLOTS  = 32;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(2 * SLOTS);
    localparam int REV_W  = $clog2(4 * SLOTS);

    localparam int CMD_W  = 4;
    localparam int JUMP_W = 5;
    localparam int MIN_W  = 6;
    localparam int IDX_W  = 5;
    localparam int OFFS_W = 7;
    localparam int MJ_W   = 5;
    localparam int SUM_W  = CNT_W + 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ        = 4'd0,
        CMD_REQ_WRITE   = 4'd1,
        CMD_DONE_WRITE  = 4'd2,
        CMD_TOGGLE      = 4'd3,
        CMD_REFILL      = 4'd4,
        CMD_SET_TOGGLE  = 4'd5,
        CMD_SET_SEEK    = 4'd6,
        CMD_FLUSH       = 4'd7,
        CMD_SET_MIN     = 4'd8
    } cmd_t;

endpackage

### src/bidirectional_frame_ring_index_manager_top.sv
// A word accepted into the input register is processed by the update pass, and its result
// is captured in the result register, from which it is presented at the output.
// Throughput: one word per cycle unless stalled; the single update pass sets the rate.
// Output stall holds the result register and back-pressures the input register.
// Reset (rst_n low, asynchronous) clears indices, counters and direction to forward,
// sets the minimum free count to half the slot count and empties both registers.
`include "assert_macros.svh"

module bidirectional_frame_ring_index_manager_top
    import bfrim_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [CMD_W-1:0]  command,
    input  logic [JUMP_W-1:0] jump_frames,
    input  logic [MIN_W-1:0]  min_images,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              accepted,
    output logic [IDX_W-1:0]  slot_index,
    output logic [OFFS_W-1:0] offset_frames,
    output logic [MJ_W-1:0]   max_jump,
    output logic              reverse_mode,
    output logic              reverse_pending,
    output logic              buffer_empty,
    output logic              refill_needed
);

    logic              in_valid_reg;
    cmd_t              cmd_reg;
    logic [JUMP_W-1:0] jump_reg;
    logic [MIN_W-1:0]  mini_reg;

    logic [SLOT_W-1:0] rs_reg, rs_next;
    logic [SLOT_W-1:0] ws_reg, ws_next;
    logic [CNT_W-1:0]  fa_reg, fa_next;
    logic [CNT_W-1:0]  fb_reg, fb_next;
    logic [CNT_W-1:0]  rt_reg, rt_next;
    logic [REV_W-1:0]  rl_reg, rl_next;
    logic              dir_reg, dir_next;
    logic [MIN_W-1:0]  mf_reg, mf_next;

    logic              out_valid_reg;
    logic              acc_reg, acc_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [OFFS_W-1:0] offs_reg, offs_next;
    logic [MJ_W-1:0]   mj_reg, mj_next;
    logic              rmode_reg, rpend_reg, empty_reg, refill_reg;

    logic              advance;
    logic              take_in;
    logic [CNT_W:0]    sum_ab;
    logic [SUM_W-1:0]  sum_fa_mf;
    logic [REV_W-1:0]  rl_dec;
    logic [SLOT_W-1:0] fb_jump;
    logic [MJ_W-1:0]   mj_free;
    logic              block_unwritten;

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign take_in  = in_valid && !in_stall;

    assign sum_ab          = {1'b0, fa_reg} + {1'b0, fb_reg};
    assign sum_fa_mf       = SUM_W'(fa_reg) + SUM_W'(mf_reg);
    assign rl_dec          = rl_reg - REV_W'(dir_reg);
    assign fb_jump         = fb_reg[SLOT_W-1:0] - SLOT_W'(jump_reg);
    assign mj_free         = MJ_W'(CNT_W'(SLOTS - 1) - fa_reg);
    assign block_unwritten = (rl_reg == REV_W'(rt_reg)) && (rt_reg != '0);

    always_comb
    begin
        rs_next   = rs_reg;
        ws_next   = ws_reg;
        fa_next   = fa_reg;
        fb_next   = fb_reg;
        rt_next   = rt_reg;
        rl_next   = rl_reg;
        dir_next  = dir_reg;
        mf_next   = mf_reg;
        acc_next  = 1'b0;
        idx_next  = '0;
        offs_next = '0;
        mj_next   = '0;
        case (cmd_reg)
            CMD_READ:
            begin
                if (fa_reg != '0)
                begin
                    acc_next = 1'b1;
                    idx_next = IDX_W'(rs_reg);
                    rs_next  = dir_reg ? rs_reg - SLOT_W'(1) : rs_reg + SLOT_W'(1);
                    fa_next  = fa_reg - CNT_W'(1);
                    fb_next  = fb_reg + CNT_W'(1);
                end
            end
            CMD_REQ_WRITE:
            begin
                if (fa_reg < CNT_W'(SLOTS - 1))
                begin
                    acc_next = 1'b1;
                    idx_next = IDX_W'(ws_reg);
                end
            end
            CMD_DONE_WRITE:
            begin
                acc_next = 1'b1;
                ws_next  = ws_reg + SLOT_W'(1);
                rl_next  = rl_dec;
                if (sum_ab == (CNT_W + 1)'(SLOTS))
                begin
                    fb_next = fb_reg - CNT_W'(1);
                end
                if (dir_reg)
                begin
                    if (rl_dec == '0)
                    begin
                        fa_next = fa_reg + rt_reg;
                    end
                end
                else
                begin
                    fa_next = fa_reg + CNT_W'(1);
                end
            end
            CMD_TOGGLE:
            begin
                if (fb_reg != '0)
                begin
                    acc_next = 1'b1;
                    dir_next = !dir_reg;
                    if (!dir_reg)
                    begin
                        offs_next = OFFS_W'(sum_ab);
                        mj_next   = mj_free;
                        rs_next   = rs_reg - SLOT_W'(2);
                        ws_next   = rs_reg - fb_reg[SLOT_W-1:0] - SLOT_W'(1);
                    end
                    else
                    begin
                        offs_next = OFFS_W'(sum_ab) + OFFS_W'(rl_reg);
                        if (!block_unwritten)
                        begin
                            ws_next = rs_reg + fb_reg[SLOT_W-1:0] + SLOT_W'(1);
                        end
                        rs_next = rs_reg + SLOT_W'(2);
                    end
                    fa_next = fb_reg - CNT_W'(1);
                    fb_next = fa_reg + CNT_W'(1);
                    rt_next = '0;
                    rl_next = '0;
                    mf_next = MIN_W'(SLOTS / 2);
                end
            end
            CMD_REFILL:
            begin
                if (sum_fa_mf < SUM_W'(SLOTS))
                begin
                    acc_next  = 1'b1;
                    offs_next = OFFS_W'(rt_reg);
                    mj_next   = mj_free;
                end
            end
            CMD_SET_TOGGLE, CMD_SET_SEEK:
            begin
                acc_next = 1'b1;
                if (cmd_reg == CMD_SET_TOGGLE)
                begin
                    ws_next = ws_reg - SLOT_W'(jump_reg) + SLOT_W'(1);
                end
                else
                begin
                    ws_next = rs_reg - fa_reg[SLOT_W-1:0] - SLOT_W'(jump_reg) + SLOT_W'(1);
                end
                fb_next = CNT_W'(fb_jump);
                rt_next = CNT_W'(jump_reg);
                rl_next = REV_W'(jump_reg);
            end
            CMD_FLUSH:
            begin
                acc_next = 1'b1;
                rs_next  = '0;
                ws_next  = '0;
                fa_next  = '0;
                fb_next  = '0;
                rt_next  = '0;
                rl_next  = '0;
                mf_next  = MIN_W'(SLOTS / 2);
            end
            CMD_SET_MIN:
            begin
                acc_next = 1'b1;
                mf_next  = mini_reg;
            end
            default:
            begin
                acc_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            rs_reg        <= '0;
            ws_reg        <= '0;
            fa_reg        <= '0;
            fb_reg        <= '0;
            rt_reg        <= '0;
            rl_reg        <= '0;
            dir_reg       <= 1'b0;
            mf_reg        <= MIN_W'(SLOTS / 2);
        end
        else
        begin
            if (take_in)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                rs_reg        <= rs_next;
                ws_reg        <= ws_next;
                fa_reg        <= fa_next;
                fb_reg        <= fb_next;
                rt_reg        <= rt_next;
                rl_reg        <= rl_next;
                dir_reg       <= dir_next;
                mf_reg        <= mf_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            cmd_reg  <= cmd_t'(command);
            jump_reg <= jump_frames;
            mini_reg <= min_images;
        end
        if (advance)
        begin
            acc_reg    <= acc_next;
            idx_reg    <= idx_next;
            offs_reg   <= offs_next;
            mj_reg     <= mj_next;
            rmode_reg  <= dir_next;
            rpend_reg  <= !rl_next[REV_W-1] && (rl_next != '0);
            empty_reg  <= (fa_next == '0);
            refill_reg <= dir_next && (rl_next == '0);
        end
    end

    assign out_valid       = out_valid_reg;
    assign accepted        = acc_reg;
    assign slot_index      = idx_reg;
    assign offset_frames   = offs_reg;
    assign max_jump        = mj_reg;
    assign reverse_mode    = rmode_reg;
    assign reverse_pending = rpend_reg;
    assign buffer_empty    = empty_reg;
    assign refill_needed   = refill_reg;

    `ASSERT_CLK(a_refill_in_reverse, out_valid |-> (!refill_needed || reverse_mode), "refill without reverse")
    `ASSERT_CLK(a_pending_vs_refill, out_valid |-> !(reverse_pending && refill_needed), "pending and refill both set")
    `ASSERT_NEXT(a_reject_holds, advance && !acc_next, $stable(rs_reg) && $stable(ws_reg) && $stable(fa_reg) && $stable(fb_reg) && $stable(rl_reg) && $stable(dir_reg), "rejected command changed state")
    `ASSERT_NEXT(a_flush_clears, advance && (cmd_reg == CMD_FLUSH), (fa_reg == '0) && (rs_reg == '0) && (rl_reg == '0) && $stable(dir_reg), "flush did not clear")

endmodule

### verif/bidirectional_frame_ring_index_manager_top_test.sv
module bidirectional_frame_ring_index_manager_top_test;
    import bfrim_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam logic [CMD_W-1:0] CMD_TOP_KNOWN = CMD_SET_MIN;
    localparam logic [CMD_W-1:0] CMD_TOP_CODE = {CMD_W{1'b1}};

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [JUMP_W-1:0] jump;
        logic [MIN_W-1:0]  mini;
    } ring_cmd_t;

    typedef struct packed {
        logic              accepted;
        logic [IDX_W-1:0]  slot_index;
        logic [OFFS_W-1:0] offset_frames;
        logic [MJ_W-1:0]   max_jump;
        logic              reverse_mode;
        logic              reverse_pending;
        logic              buffer_empty;
        logic              refill_needed;
    } ring_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [CMD_W-1:0]  command = '0;
    logic [JUMP_W-1:0] jump_frames = '0;
    logic [MIN_W-1:0]  min_images = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic              accepted;
    logic [IDX_W-1:0]  slot_index;
    logic [OFFS_W-1:0] offset_frames;
    logic [MJ_W-1:0]   max_jump;
    logic              reverse_mode;
    logic              reverse_pending;
    logic              buffer_empty;
    logic              refill_needed;

    logic [SLOT_W-1:0]       rd_slot = '0;
    logic [SLOT_W-1:0]       wr_slot = '0;
    logic [CNT_W-1:0]        ahead = '0;
    logic [CNT_W-1:0]        behind = '0;
    logic [CNT_W-1:0]        rev_total = '0;
    logic signed [REV_W-1:0] rev_left = '0;
    logic                    dir_rev = 1'b0;
    logic [MIN_W-1:0]        free_min = MIN_W'(SLOTS / 2);

    ring_cmd_t    pending_words[$];
    ring_result_t expected_results[$];

    int  queued_total = 0;
    int  words_sent = 0;
    int  words_in = 0;
    int  results_seen = 0;
    int  applied_count = 0;
    int  reverse_count = 0;
    int  failures = 0;
    int  gap_left = 0;
    int  stall_left = 0;
    int  quiet_cycles = 0;
    bit  idle_on = 1'b0;

    bidirectional_frame_ring_index_manager_top i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .command         (command),
        .jump_frames     (jump_frames),
        .min_images      (min_images),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .accepted        (accepted),
        .slot_index      (slot_index),
        .offset_frames   (offset_frames),
        .max_jump        (max_jump),
        .reverse_mode    (reverse_mode),
        .reverse_pending (reverse_pending),
        .buffer_empty    (buffer_empty),
        .refill_needed   (refill_needed)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic ring_result_t apply_command(ring_cmd_t w);
        ring_result_t r;
        int fa;
        int fb;
        int rt;
        int rl;
        int rs;
        int ws;
        int fm;
        int jmp;
        logic blk;
        fa = ahead;
        fb = behind;
        rt = rev_total;
        rl = rev_left;
        rs = rd_slot;
        ws = wr_slot;
        fm = free_min;
        jmp = w.jump;
        r = '0;
        case (w.command)
            CMD_READ:
            begin
                if (fa > 0)
                begin
                    r.accepted = 1'b1;
                    r.slot_index = IDX_W'(rs);
                    rd_slot = dir_rev ? SLOT_W'(rs - 1) : SLOT_W'(rs + 1);
                    ahead = CNT_W'(fa - 1);
                    behind = CNT_W'(fb + 1);
                end
            end
            CMD_REQ_WRITE:
            begin
                if (SLOTS - fa - 1 > 0)
                begin
                    r.accepted = 1'b1;
                    r.slot_index = IDX_W'(ws);
                end
            end
            CMD_DONE_WRITE:
            begin
                r.accepted = 1'b1;
                wr_slot = SLOT_W'(ws + 1);
                rev_left = REV_W'(rl - int'(dir_rev));
                if (fa + fb == SLOTS)
                    behind = CNT_W'(fb - 1);
                if (dir_rev)
                begin
                    if (rev_left == 0)
                        ahead = CNT_W'(fa + rt);
                end
                else
                    ahead = CNT_W'(fa + 1);
            end
            CMD_TOGGLE:
            begin
                if (fb > 0)
                begin
                    blk = (rl == rt) && (rt > 0);
                    r.accepted = 1'b1;
                    dir_rev = !dir_rev;
                    if (dir_rev)
                    begin
                        r.offset_frames = OFFS_W'(fa + fb);
                        r.max_jump = MJ_W'(SLOTS - fa - 1);
                        rd_slot = SLOT_W'(rs - 2);
                        wr_slot = SLOT_W'(rs - 2 - (fb - 1));
                    end
                    else
                    begin
                        r.offset_frames = OFFS_W'(fa + fb + rl);
                        if (!blk)
                            wr_slot = SLOT_W'(rs + fb + 1);
                        rd_slot = SLOT_W'(rs + 2);
                    end
                    ahead = CNT_W'(fb - 1);
                    behind = CNT_W'(fa + 1);
                    rev_total = '0;
                    rev_left = '0;
                    free_min = MIN_W'(SLOTS / 2);
                end
            end
            CMD_REFILL:
            begin
                if (SLOTS - fa > fm)
                begin
                    r.accepted = 1'b1;
                    r.offset_frames = OFFS_W'(rt);
                    r.max_jump = MJ_W'(SLOTS - fa - 1);
                end
            end
            CMD_SET_TOGGLE, CMD_SET_SEEK:
            begin
                r.accepted = 1'b1;
                if (w.command == CMD_SET_TOGGLE)
                    wr_slot = SLOT_W'(ws - jmp + 1);
                else
                    wr_slot = SLOT_W'(rs - fa - jmp + 1);
                behind = CNT_W'((fb - jmp) & (SLOTS - 1));
                rev_total = CNT_W'(jmp);
                rev_left = REV_W'(jmp);
            end
            CMD_FLUSH:
            begin
                r.accepted = 1'b1;
                rd_slot = '0;
                wr_slot = '0;
                ahead = '0;
                behind = '0;
                rev_total = '0;
                rev_left = '0;
                free_min = MIN_W'(SLOTS / 2);
            end
            CMD_SET_MIN:
            begin
                r.accepted = 1'b1;
                free_min = w.mini;
            end
            default:
            begin
            end
        endcase
        r.reverse_mode = dir_rev;
        r.reverse_pending = rev_left > 0;
        r.buffer_empty = ahead == 0;
        r.refill_needed = dir_rev && rev_left == 0;
        return r;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            failures++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    task automatic push_word(logic [CMD_W-1:0] c, int jmp, int mini);
        ring_cmd_t w;
        w.command = c;
        w.jump = JUMP_W'(jmp);
        w.mini = MIN_W'(mini);
        pending_words.push_back(w);
        queued_total++;
    endtask

    task automatic push_cmd(logic [CMD_W-1:0] c);
        push_word(c, $urandom_range(0, 31), $urandom_range(0, 63));
    endtask

    task automatic queue_random_words(int n);
        int start;
        int k;
        int jmp;
        start = queued_total;
        while (queued_total - start < n)
        begin
            k = $urandom_range(1, 12);
            jmp = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 6);
            case ($urandom_range(0, 11))
                0, 1, 2:
                    repeat (k)
                    begin
                        push_cmd(CMD_REQ_WRITE);
                        push_cmd(CMD_DONE_WRITE);
                    end
                3, 4:
                    repeat (k) push_cmd(CMD_READ);
                5:
                begin
                    push_cmd(CMD_TOGGLE);
                    push_cmd(CMD_REFILL);
                    push_word(CMD_SET_TOGGLE, jmp, $urandom_range(0, 63));
                    repeat (jmp)
                    begin
                        push_cmd(CMD_REQ_WRITE);
                        push_cmd(CMD_DONE_WRITE);
                    end
                    repeat ($urandom_range(0, jmp)) push_cmd(CMD_READ);
                end
                6:
                begin
                    push_word(CMD_SET_SEEK, jmp, $urandom_range(0, 63));
                    repeat (jmp) push_cmd(CMD_DONE_WRITE);
                    push_cmd(CMD_REFILL);
                end
                7:
                    push_cmd(CMD_W'($urandom_range(0, int'(CMD_TOP_CODE))));
                8:
                begin
                    push_word(CMD_SET_MIN, $urandom_range(0, 31), $urandom_range(0, 63));
                    push_cmd(CMD_REFILL);
                end
                9:
                begin
                    push_cmd(CMD_TOGGLE);
                    repeat (k) push_cmd(CMD_READ);
                end
                10:
                begin
                    repeat (SLOTS + 1) push_cmd(CMD_DONE_WRITE);
                    push_cmd(CMD_REQ_WRITE);
                    push_cmd(CMD_REFILL);
                end
                default:
                    push_cmd(($urandom_range(0, 2) == 0) ? CMD_FLUSH : CMD_REFILL);
            endcase
        end
    endtask

    task automatic wait_ring_idle();
        while (pending_words.size() != 0 || words_in != words_sent ||
               expected_results.size() != 0)
            @(posedge clk);
    endtask

    always @(negedge clk)
    begin
        ring_cmd_t next_word;
        if (rst_n && !(in_valid && words_in != words_sent))
        begin
            if (idle_on && gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_words.size() > 0)
            begin
                next_word = pending_words.pop_front();
                in_valid <= 1'b1;
                command <= next_word.command;
                jump_frames <= next_word.jump;
                min_images <= next_word.mini;
                words_sent++;
                if (idle_on && $urandom_range(0, 9) == 0)
                    gap_left = $urandom_range(1, 19);
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (idle_on && stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
            if (idle_on && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 19);
        end
    end

    always @(posedge clk)
    begin
        ring_cmd_t    seen;
        ring_result_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                seen.command = command;
                seen.jump = jump_frames;
                seen.mini = min_images;
                expected_results.push_back(apply_command(seen));
                words_in++;
            end
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    failures++;
                    $error("result word with no command pending");
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (want.accepted)
                        applied_count++;
                    if (want.reverse_mode)
                        reverse_count++;
                    check_field("accepted", want.accepted, accepted);
                    check_field("slot_index", want.slot_index, slot_index);
                    check_field("offset_frames", want.offset_frames, offset_frames);
                    check_field("max_jump", want.max_jump, max_jump);
                    check_field("reverse_mode", want.reverse_mode, reverse_mode);
                    check_field("reverse_pending", want.reverse_pending, reverse_pending);
                    check_field("buffer_empty", want.buffer_empty, buffer_empty);
                    check_field("refill_needed", want.refill_needed, refill_needed);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        push_word(CMD_READ, 0, 0);
        push_word(CMD_TOGGLE, 0, 0);
        push_word(CMD_REFILL, 0, 0);
        push_word(CMD_W'(CMD_TOP_KNOWN + 1), 31, 63);
        push_word(CMD_TOP_CODE, 0, 0);
        push_word(CMD_REQ_WRITE, 0, 0);
        repeat (3) push_word(CMD_DONE_WRITE, 0, 0);
        repeat (2) push_word(CMD_READ, 0, 0);
        push_word(CMD_TOGGLE, 0, 0);
        push_word(CMD_REFILL, 0, 0);
        push_word(CMD_SET_TOGGLE, 2, 0);
        repeat (2) push_word(CMD_DONE_WRITE, 0, 0);
        push_word(CMD_READ, 0, 0);
        push_word(CMD_TOGGLE, 0, 0);
        push_word(CMD_SET_SEEK, 31, 0);
        push_word(CMD_SET_SEEK, 0, 0);
        push_word(CMD_SET_MIN, 0, 0);
        push_word(CMD_REFILL, 0, 0);
        push_word(CMD_SET_MIN, 31, 63);
        push_word(CMD_FLUSH, 0, 0);
        push_word(CMD_SET_MIN, 0, 32);
        wait_ring_idle();

        idle_on = 1'b1;
        queue_random_words(200);
        wait_ring_idle();
        queue_random_words(120);
        wait_ring_idle();
        idle_on = 1'b0;
        queue_random_words(80);
        wait_ring_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d command words, checked %0d result words (%0d applied).",
                 words_sent, results_seen, applied_count);
        $display("Results in reverse play: %0d; mismatches: %0d.", reverse_count, failures);
        if (failures == 0 && expected_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
